FILE: src/fixed_format_spec_checker_defines.svh
// Assertion macros for the fixed-format spec checker.
// Used by fixed_format_spec_checker.sv; expects clk and rst_n in scope.
`ifndef FIXED_FORMAT_SPEC_CHECKER_DEFINES_SVH
`define FIXED_FORMAT_SPEC_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only out of reset.
`define FFSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define FFSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFSC_ASSERT(lbl, prop, msg)
`define FFSC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/ffsc_pkg.sv
// Shared constants and types for the fixed-format spec checker.
// No dependencies.
`default_nettype none

package ffsc_pkg;

  localparam int unsigned MAX_FLAGS  = 5;
  localparam int unsigned MAX_DIGITS = 2;

  localparam int unsigned FLAG_CNT_W = 3;
  localparam int unsigned DIG_CNT_W  = 2;
  localparam int unsigned PREC_W     = 7;

  localparam logic [PREC_W-1:0] PREC_DEFAULT = 7'd6;
  localparam logic [PREC_W-1:0] PREC_LIMIT   = 7'd127;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25; // '%'
  localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
  localparam logic [7:0] CH_SPACE = 8'h20; // ' '
  localparam logic [7:0] CH_HASH  = 8'h23; // '#'
  localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CH_NINE  = 8'h39; // '9'
  localparam logic [7:0] CH_DOT   = 8'h2E; // '.'
  localparam logic [7:0] CH_LOW_F = 8'h66; // 'f'
  localparam logic [7:0] CH_UP_F  = 8'h46; // 'F'

  typedef enum logic [5:0] {
    PH_PCT    = 6'b000001,
    PH_FLAGS  = 6'b000010,
    PH_WIDTH  = 6'b000100,
    PH_PREC   = 6'b001000,
    PH_CONV   = 6'b010000,
    PH_REJECT = 6'b100000
  } phase_t;

  function automatic logic is_flag(input logic [7:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE) ||
           (c == CH_HASH) || (c == CH_ZERO);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_conv(input logic [7:0] c);
    return (c == CH_LOW_F) || (c == CH_UP_F);
  endfunction

endpackage

`default_nettype wire

FILE: src/fixed_format_spec_checker.sv
// Fixed-format spec checker: input register, per-byte parse logic, result register.
// Result path: a zero byte's transaction loads the input register, and the byte then
//   loads the result register, which drives out_tvalid.
// Throughput: one byte per cycle; a zero byte waits in the input register while the
//   previous result is still unread, other bytes pass on regardless.
// Reset (rst_n low, synchronous): parser back to expecting '%', both stages empty.
// Depends on ffsc_pkg and fixed_format_spec_checker_defines.svh.
`default_nettype none

module fixed_format_spec_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] ch
  // result channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] accepted, [7:1] precision
);

  // ---------------------------------------------------------------
  // Input stage: one byte held until the parser consumes it.
  // ---------------------------------------------------------------
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_adv;
  logic       out_free;
  logic       s1_is_nul;

  // Result register
  logic                         out_valid_r;
  logic                         out_acc_r;
  logic [ffsc_pkg::PREC_W-1:0]  out_prec_r;

  // Parser state
  ffsc_pkg::phase_t                 phase_r, phase_nxt;
  logic [ffsc_pkg::FLAG_CNT_W-1:0]  flag_cnt_r, flag_cnt_nxt;
  logic [ffsc_pkg::DIG_CNT_W-1:0]   wdig_cnt_r, wdig_cnt_nxt;
  logic [ffsc_pkg::DIG_CNT_W-1:0]   pdig_cnt_r, pdig_cnt_nxt;
  logic [ffsc_pkg::PREC_W-1:0]      prec_r, prec_nxt;

  // prec * 10 + digit; 127 * 10 + 9 fits in 11 bits
  logic [10:0] prec_mac;

  assign s1_is_nul = (s1_ch_r == ffsc_pkg::CH_NUL);
  assign out_free  = !out_valid_r || out_tready;
  // Non-terminator bytes never need the result slot.
  assign s1_adv    = s1_valid_r && (!s1_is_nul || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r <= in_tdata;
    end
  end

  // ---------------------------------------------------------------
  // Parse step
  // ---------------------------------------------------------------
  assign prec_mac = ({4'd0, prec_r} * 11'd10) + {3'd0, s1_ch_r - ffsc_pkg::CH_ZERO};

  always_comb begin
    phase_nxt    = phase_r;
    flag_cnt_nxt = flag_cnt_r;
    wdig_cnt_nxt = wdig_cnt_r;
    pdig_cnt_nxt = pdig_cnt_r;
    prec_nxt     = prec_r;

    if (s1_is_nul) begin
      // terminator: back to the start state
      phase_nxt    = ffsc_pkg::PH_PCT;
      flag_cnt_nxt = '0;
      wdig_cnt_nxt = '0;
      pdig_cnt_nxt = '0;
      prec_nxt     = ffsc_pkg::PREC_DEFAULT;
    end else begin
      unique case (phase_r) inside
        ffsc_pkg::PH_PCT: begin
          phase_nxt = (s1_ch_r == ffsc_pkg::CH_PCT) ? ffsc_pkg::PH_FLAGS
                                                     : ffsc_pkg::PH_REJECT;
        end
        ffsc_pkg::PH_FLAGS, ffsc_pkg::PH_WIDTH: begin
          // '0' is a flag only while still in the flags phase
          if ((phase_r == ffsc_pkg::PH_FLAGS) && ffsc_pkg::is_flag(s1_ch_r)) begin
            if (flag_cnt_r >= ffsc_pkg::FLAG_CNT_W'(ffsc_pkg::MAX_FLAGS)) begin
              phase_nxt = ffsc_pkg::PH_REJECT;
            end else begin
              flag_cnt_nxt = flag_cnt_r + 1'b1;
            end
          end else if (ffsc_pkg::is_digit(s1_ch_r)) begin
            if (wdig_cnt_r >= ffsc_pkg::DIG_CNT_W'(ffsc_pkg::MAX_DIGITS)) begin
              phase_nxt = ffsc_pkg::PH_REJECT;
            end else begin
              wdig_cnt_nxt = wdig_cnt_r + 1'b1;
              phase_nxt    = ffsc_pkg::PH_WIDTH;
            end
          end else if (s1_ch_r == ffsc_pkg::CH_DOT) begin
            prec_nxt  = '0;   // bare dot means precision 0
            phase_nxt = ffsc_pkg::PH_PREC;
          end else if (ffsc_pkg::is_conv(s1_ch_r)) begin
            phase_nxt = ffsc_pkg::PH_CONV;
          end else begin
            phase_nxt = ffsc_pkg::PH_REJECT;
          end
        end
        ffsc_pkg::PH_PREC: begin
          if (ffsc_pkg::is_digit(s1_ch_r)) begin
            if (pdig_cnt_r >= ffsc_pkg::DIG_CNT_W'(ffsc_pkg::MAX_DIGITS)) begin
              phase_nxt = ffsc_pkg::PH_REJECT;
            end else begin
              pdig_cnt_nxt = pdig_cnt_r + 1'b1;
              // saturate at PREC_LIMIT; a third digit is rejected above
              prec_nxt = (prec_mac > {4'd0, ffsc_pkg::PREC_LIMIT}) ?
                         ffsc_pkg::PREC_LIMIT : prec_mac[ffsc_pkg::PREC_W-1:0];
            end
          end else if (ffsc_pkg::is_conv(s1_ch_r)) begin
            phase_nxt = ffsc_pkg::PH_CONV;
          end else begin
            phase_nxt = ffsc_pkg::PH_REJECT;
          end
        end
        ffsc_pkg::PH_CONV, ffsc_pkg::PH_REJECT: begin
          // anything but the terminator after the conversion is an error
          phase_nxt = ffsc_pkg::PH_REJECT;
        end
        default: begin
          phase_nxt = ffsc_pkg::PH_REJECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ffsc_pkg::PH_PCT;
      flag_cnt_r <= '0;
      wdig_cnt_r <= '0;
      pdig_cnt_r <= '0;
      prec_r     <= ffsc_pkg::PREC_DEFAULT;
    end else if (s1_adv) begin
      phase_r    <= phase_nxt;
      flag_cnt_r <= flag_cnt_nxt;
      wdig_cnt_r <= wdig_cnt_nxt;
      pdig_cnt_r <= pdig_cnt_nxt;
      prec_r     <= prec_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Result register: loaded on the terminator only
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_is_nul) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_is_nul) begin
      out_acc_r  <= (phase_r == ffsc_pkg::PH_CONV);
      out_prec_r <= (phase_r == ffsc_pkg::PH_CONV) ? prec_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_prec_r, out_acc_r};

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
`include "fixed_format_spec_checker_defines.svh"

  `FFSC_ASSERT(a_rej_prec_zero,
    (out_valid_r && !out_acc_r) |-> (out_prec_r == '0),
    "rejected result carries nonzero precision")
  `FFSC_ASSERT(a_cnt_limits,
    (flag_cnt_r <= ffsc_pkg::FLAG_CNT_W'(ffsc_pkg::MAX_FLAGS)) &&
    (wdig_cnt_r <= ffsc_pkg::DIG_CNT_W'(ffsc_pkg::MAX_DIGITS)) &&
    (pdig_cnt_r <= ffsc_pkg::DIG_CNT_W'(ffsc_pkg::MAX_DIGITS)),
    "parser count past its limit")
  `FFSC_ASSERT(a_nul_gives_result,
    (s1_adv && s1_is_nul) |=> (out_valid_r && (phase_r == ffsc_pkg::PH_PCT)),
    "terminator did not produce a result and restart")
  `FFSC_ASSERT_ALWAYS(a_reset_clears,
    !rst_n |=> (!out_valid_r && !s1_valid_r && (phase_r == ffsc_pkg::PH_PCT)),
    "reset did not clear the pipeline")

endmodule

`default_nettype wire

FILE: tb/tb_fixed_format_spec_checker.sv
// Self-checking testbench for fixed_format_spec_checker: directed and random spec strings
// are streamed in, each verdict checked against a table or a behavioral parser kept here.
// Depends on ffsc_pkg and the fixed_format_spec_checker RTL.
`timescale 1ns / 100ps

module tb_fixed_format_spec_checker;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DIR_ROWS    = 6;
  localparam int unsigned RAND_BYTES  = 400;
  localparam int unsigned DRAIN_CYC   = 8;  // result register plus a little slack

  // One verdict, laid out as out_tdata: [0] accepted, [7:1] precision.
  typedef struct packed {
    logic [6:0] prec;
    logic       acc;
  } verdict_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] ch
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [0] accepted, [7:1] precision

  fixed_format_spec_checker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Verdicts still owed by the block, oldest first.
  verdict_t verdict_q[$];

  int unsigned cycle_cnt  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_bytes    = 0;
  int unsigned n_strings  = 0;
  int unsigned n_verdicts = 0;
  int unsigned n_accepted = 0;

  // Sender pacing: vld_on mirrors in_tvalid so it is never assigned twice in one step.
  bit          vld_on     = 1'b0;
  int unsigned burst_left = 4;

  // Parser state of the behavioral copy.
  ffsc_pkg::phase_t ph;
  logic [2:0]       n_flags;
  logic [1:0]       n_wdig;
  logic [1:0]       n_pdig;
  logic [6:0]       prec_acc;

  // Directed strings; a zero byte is appended to each when it is sent.
  string    spec_tab     [DIR_ROWS] = '{
    "",           // empty string
    "%f",         // shortest valid spec, default precision
    "%0+- #0f",   // five flags, then a sixth '0' counts as a flag and rejects
    "%9.99F",     // uppercase conversion, largest two-digit precision
    "%.f",        // dot with no digits
    "%.F\377"     // byte after the conversion (all ones) rejects
  };
  verdict_t spec_verdict [DIR_ROWS] = '{
    {7'd0,  1'b0},
    {7'd6,  1'b1},
    {7'd0,  1'b0},
    {7'd99, 1'b1},
    {7'd0,  1'b1},
    {7'd0,  1'b0}
  };

  logic [7:0] flag_set [5] = '{ffsc_pkg::CH_MINUS, ffsc_pkg::CH_PLUS, ffsc_pkg::CH_SPACE,
                               ffsc_pkg::CH_HASH, ffsc_pkg::CH_ZERO};
  logic [7:0] spec_q[$];

  task automatic clear_parse_state();
    ph       = ffsc_pkg::PH_PCT;
    n_flags  = '0;
    n_wdig   = '0;
    n_pdig   = '0;
    prec_acc = ffsc_pkg::PREC_DEFAULT;
  endtask

  // Advances the parser by one byte; done is set when the byte closes a string.
  task automatic parse_spec_byte(input logic [7:0] c, output bit done, output verdict_t v);
    bit          is_dig;
    bit          is_flg;
    bit          is_cnv;
    int unsigned nxt;
    is_dig = (c >= ffsc_pkg::CH_ZERO) && (c <= ffsc_pkg::CH_NINE);
    is_flg = (c == ffsc_pkg::CH_MINUS) || (c == ffsc_pkg::CH_PLUS) ||
             (c == ffsc_pkg::CH_SPACE) || (c == ffsc_pkg::CH_HASH) ||
             (c == ffsc_pkg::CH_ZERO);
    is_cnv = (c == ffsc_pkg::CH_LOW_F) || (c == ffsc_pkg::CH_UP_F);
    done   = 1'b0;
    v      = '0;
    if (c == ffsc_pkg::CH_NUL) begin
      done   = 1'b1;
      v.acc  = (ph == ffsc_pkg::PH_CONV);
      v.prec = v.acc ? prec_acc : 7'd0;
      clear_parse_state();
    end else if (ph == ffsc_pkg::PH_PCT) begin
      ph = (c == ffsc_pkg::CH_PCT) ? ffsc_pkg::PH_FLAGS : ffsc_pkg::PH_REJECT;
    end else if (ph == ffsc_pkg::PH_FLAGS && is_flg) begin
      // '0' is still a flag here; the count saturates and the extra one rejects
      if (n_flags >= ffsc_pkg::MAX_FLAGS) ph = ffsc_pkg::PH_REJECT;
      else n_flags++;
    end else if (ph == ffsc_pkg::PH_FLAGS || ph == ffsc_pkg::PH_WIDTH) begin
      if (is_dig) begin
        if (n_wdig >= ffsc_pkg::MAX_DIGITS) ph = ffsc_pkg::PH_REJECT;
        else begin
          n_wdig++;
          ph = ffsc_pkg::PH_WIDTH;
        end
      end else if (c == ffsc_pkg::CH_DOT) begin
        prec_acc = '0;
        ph       = ffsc_pkg::PH_PREC;
      end else if (is_cnv) begin
        ph = ffsc_pkg::PH_CONV;
      end else begin
        ph = ffsc_pkg::PH_REJECT;
      end
    end else if (ph == ffsc_pkg::PH_PREC) begin
      if (is_dig) begin
        if (n_pdig >= ffsc_pkg::MAX_DIGITS) ph = ffsc_pkg::PH_REJECT;
        else begin
          nxt = prec_acc * 10 + (c - ffsc_pkg::CH_ZERO);
          n_pdig++;
          prec_acc = (nxt > ffsc_pkg::PREC_LIMIT) ? ffsc_pkg::PREC_LIMIT : nxt[6:0];
        end
      end else if (is_cnv) begin
        ph = ffsc_pkg::PH_CONV;
      end else begin
        ph = ffsc_pkg::PH_REJECT;
      end
    end else begin
      // anything after the conversion, or inside a rejected string
      ph = ffsc_pkg::PH_REJECT;
    end
  endtask

  // Drops valid (once), then waits out the idle span given by n.
  task automatic idle(input int unsigned n);
    if (vld_on) begin
      in_tvalid <= 1'b0;
      vld_on = 1'b0;
    end
    repeat (n) @(posedge clk);
  endtask

  // Offers one byte, waits for its transaction, predicts, then paces the burst.
  task automatic send_byte(input logic [7:0] ch, input bit use_tab, input verdict_t tab_v);
    bit       done;
    verdict_t v;
    in_tdata <= ch;
    if (!vld_on) begin
      in_tvalid <= 1'b1;
      vld_on = 1'b1;
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_bytes++;
    parse_spec_byte(ch, done, v);
    if (done) begin
      verdict_q.push_back(use_tab ? tab_v : v);
      n_strings++;
    end
    burst_left--;
    if (burst_left == 0) begin
      idle($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 8);
    end
  endtask

  // Receiver: pattern chosen by cycle_cnt[8:7], in turn always ready, coin flip,
  // short periodic stalls, long periodic stalls.
  always @(posedge clk) begin
    case (cycle_cnt[8:7])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= (cycle_cnt[2:0] != 3'd0);
      default: out_tready <= (cycle_cnt[4:0] < 5'd8);
    endcase
  end

  // Verdict checker.
  always @(posedge clk) begin
    verdict_t exp_v;
    verdict_t got_v;
    if (rst_n && out_tvalid && out_tready) begin
      got_v = out_tdata;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict transaction, actual acc=%0d prec=%0d",
                 $time, got_v.acc, got_v.prec);
        n_errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        n_verdicts++;
        if (got_v.acc) n_accepted++;
        if (got_v.acc !== exp_v.acc) begin
          $display("%0t: accepted mismatch, expected %0d actual %0d",
                   $time, exp_v.acc, got_v.acc);
          n_errors++;
        end
        if (got_v.prec !== exp_v.prec) begin
          $display("%0t: precision mismatch, expected %0d actual %0d",
                   $time, exp_v.prec, got_v.prec);
          n_errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_fixed_format_spec_checker: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned kind;
    int unsigned nf;
    int unsigned nw;
    int unsigned np;
    clear_parse_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings with verdicts typed in.
    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int i = 0; i < spec_tab[r].len(); i++)
        send_byte(spec_tab[r][i], 1'b0, '0);
      send_byte(ffsc_pkg::CH_NUL, 1'b1, spec_verdict[r]);
    end

    // Hold off until the directed verdicts are all back.
    idle(0);
    while (verdict_q.size() != 0) @(posedge clk);

    // Random strings: mostly well-formed with random content, some with one byte
    // corrupted, a few pure noise. Limits are overrun now and then on purpose.
    while (n_bytes < RAND_BYTES + 29) begin
      kind = $urandom_range(0, 9);
      spec_q.delete();
      if (kind < 8) begin
        spec_q.push_back(ffsc_pkg::CH_PCT);
        nf = ($urandom_range(0, 9) == 0) ? ffsc_pkg::MAX_FLAGS + 1
                                         : $urandom_range(0, ffsc_pkg::MAX_FLAGS);
        repeat (nf) spec_q.push_back(flag_set[$urandom_range(0, 4)]);
        nw = ($urandom_range(0, 9) == 0) ? ffsc_pkg::MAX_DIGITS + 1
                                         : $urandom_range(0, ffsc_pkg::MAX_DIGITS);
        repeat (nw) spec_q.push_back(8'(ffsc_pkg::CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) != 0) begin
          spec_q.push_back(ffsc_pkg::CH_DOT);
          np = ($urandom_range(0, 9) == 0) ? ffsc_pkg::MAX_DIGITS + 1
                                           : $urandom_range(0, ffsc_pkg::MAX_DIGITS);
          repeat (np) spec_q.push_back(8'(ffsc_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
        spec_q.push_back($urandom_range(0, 1) ? ffsc_pkg::CH_LOW_F : ffsc_pkg::CH_UP_F);
        if ($urandom_range(0, 11) == 0) spec_q.push_back(8'($urandom_range(1, 255)));
        if (kind >= 6) spec_q[$urandom_range(0, spec_q.size() - 1)] = 8'($urandom_range(1, 255));
      end else begin
        repeat ($urandom_range(0, 6)) spec_q.push_back(8'($urandom_range(1, 255)));
      end
      foreach (spec_q[i]) send_byte(spec_q[i], 1'b0, '0);
      send_byte(ffsc_pkg::CH_NUL, 1'b0, '0);

      // one more full drain partway through
      if (n_strings == 30) begin
        idle(0);
        while (verdict_q.size() != 0) @(posedge clk);
      end
    end

    idle(0);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Streamed %0d bytes in %0d spec strings; %0d verdicts checked, %0d accepted.",
             n_bytes, n_strings, n_verdicts, n_accepted);
    if (n_errors == 0) begin
      $display("tb_fixed_format_spec_checker: PASS");
    end else begin
      $display("tb_fixed_format_spec_checker: FAIL");
    end
    $finish;
  end

endmodule
